// ----- hdl/cph_pkg.sv -----
// Shared types and constants for the complex point hit histogram.
// Holds operation codes, result status codes, store geometry and the
// queue entry format used by the front end, the queue and the back end.
package cph_pkg;

	// store geometry and counter width
	localparam int MAX_COLS   = 256;
	localparam int MAX_ROWS   = 256;
	localparam int COUNT_BITS = 32;
	localparam int COL_BITS   = 8;
	localparam int ROW_BITS   = 8;
	localparam int ADDR_BITS  = $clog2(MAX_COLS * MAX_ROWS);
	localparam int TOTAL_BITS = 48;

	// queue between front and back
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

	// input operation codes
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// result status codes (also the work kind carried in the queue)
	localparam logic [1:0] STAT_COUNTED = 2'd0;
	localparam logic [1:0] STAT_OUTSIDE = 2'd1;
	localparam logic [1:0] STAT_CLEARED = 2'd2;
	localparam logic [1:0] STAT_READ    = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_X_MIN   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_Y_MIN   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_X_SCALE = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_Y_SCALE = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT  = 3'd5;

	// one classified item waiting for the back end
	typedef struct packed {
		logic [1:0]          kind;
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] row;
	} entry_t;

	// write side of the queue
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	// read side of the queue
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

	// back end status seen by the front end
	typedef struct packed {
		logic init_busy;
	} back_stat_t;

endpackage

// ----- hdl/cph_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the hit counter store.
module cph_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds when idle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hdl/cph_front.sv -----
// Front end: configuration registers, input transfer, pixel mapping pipeline
// and classification of each item into a queue entry. Uses cph_pkg.
module cph_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cph_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [31:0]                       cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [79:0]                       s_axis_tdata,
	input  logic [1:0]                        s_axis_tuser,
	input  cph_pkg::back_stat_t               back_stat,
	input  logic                              q_full,
	output cph_pkg::push_t                    push
);

	localparam logic [43:0] HALF = 44'h800_0000_0000;

	logic signed [31:0] x_min_q;
	logic signed [31:0] y_min_q;
	logic [31:0]        x_scale_q;
	logic [31:0]        y_scale_q;
	logic [8:0]         width_q;
	logic [8:0]         height_q;

	logic                        v_s1, v_s2, v_s3, v_s4;
	logic [1:0]                  op_s1, op_s2, op_s3, op_s4;
	logic [cph_pkg::COL_BITS-1:0] rc_s1, rc_s2, rc_s3, rc_s4;
	logic [cph_pkg::ROW_BITS-1:0] rr_s1, rr_s2, rr_s3, rr_s4;
	logic signed [32:0]          dx_s1, dy_s1;
	logic [31:0]                 mx_s2, my_s2;
	logic                        nx_s2, ny_s2, nx_s3, ny_s3;
	logic [63:0]                 px_s3, py_s3;
	logic signed [22:0]          cx_s4, cy_s4;

	logic        adv;
	logic        take;
	logic [1:0]  in_op;
	logic [31:0] in_re, in_im;
	logic [8:0]  w_eff, h_eff;
	logic        in_frame;
	cph_pkg::entry_t entry;

	// round half away from zero of +-prod/2^44 + add
	function automatic logic signed [22:0] round_axis(
		input logic [63:0] prod,
		input logic        neg,
		input logic [8:0]  add
	);
		logic [19:0]        ip;
		logic [43:0]        fr;
		logic signed [22:0] n;
		logic               up;
		ip = prod[63:44];
		fr = prod[43:0];
		if (neg) begin
			if (fr != 44'd0) begin
				n = ~$signed({3'b000, ip});
			end else begin
				n = -$signed({3'b000, ip});
			end
		end else begin
			n = $signed({3'b000, ip});
		end
		n = n + $signed({14'd0, add});
		// a negative input leaves fraction 2^44 - fr above the floor
		if (neg) begin
			up = (fr != 44'd0) && (!n[22] ? (fr <= HALF) : (fr < HALF));
		end else begin
			up = !n[22] ? (fr >= HALF) : (fr > HALF);
		end
		return n + $signed({22'd0, up});
	endfunction

	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q   <= 32'shE000_0000;
			y_min_q   <= 32'shE000_0000;
			x_scale_q <= 32'h0040_0000;
			y_scale_q <= 32'h0040_0000;
			width_q   <= 9'd256;
			height_q  <= 9'd256;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cph_pkg::REG_X_MIN:   x_min_q   <= cfg_data;
				cph_pkg::REG_Y_MIN:   y_min_q   <= cfg_data;
				cph_pkg::REG_X_SCALE: x_scale_q <= cfg_data;
				cph_pkg::REG_Y_SCALE: y_scale_q <= cfg_data;
				cph_pkg::REG_WIDTH:   width_q   <= cfg_data[8:0];
				cph_pkg::REG_HEIGHT:  height_q  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// the whole pipeline stalls when the last stage cannot enter the queue
	assign adv           = !(v_s4 && q_full);
	assign s_axis_tready = adv && !back_stat.init_busy;
	assign take          = s_axis_tvalid && s_axis_tready;

	assign in_op = s_axis_tuser;
	assign in_re = s_axis_tdata[31:0];
	assign in_im = s_axis_tdata[63:32];

	// stage valid bits; an unused opcode is dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take && (in_op != cph_pkg::OP_NONE);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// mapping datapath: difference, magnitude, product, rounding
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= in_op;
			rc_s1 <= s_axis_tdata[71:64];
			rr_s1 <= s_axis_tdata[79:72];
			dx_s1 <= $signed({in_re[31], in_re}) - $signed({x_min_q[31], x_min_q});
			dy_s1 <= $signed({y_min_q[31], y_min_q}) - $signed({in_im[31], in_im});

			op_s2 <= op_s1;
			rc_s2 <= rc_s1;
			rr_s2 <= rr_s1;
			nx_s2 <= dx_s1[32];
			ny_s2 <= dy_s1[32];
			mx_s2 <= dx_s1[32] ? 32'(-dx_s1) : dx_s1[31:0];
			my_s2 <= dy_s1[32] ? 32'(-dy_s1) : dy_s1[31:0];

			op_s3 <= op_s2;
			rc_s3 <= rc_s2;
			rr_s3 <= rr_s2;
			nx_s3 <= nx_s2;
			ny_s3 <= ny_s2;
			px_s3 <= mx_s2 * x_scale_q;
			py_s3 <= my_s2 * y_scale_q;

			op_s4 <= op_s3;
			rc_s4 <= rc_s3;
			rr_s4 <= rr_s3;
			cx_s4 <= round_axis(px_s3, nx_s3, 9'd0);
			cy_s4 <= round_axis(py_s3, ny_s3, height_q);
		end
	end

	// frame test and classification
	always_comb begin
		w_eff    = (width_q > 9'(cph_pkg::MAX_COLS)) ? 9'(cph_pkg::MAX_COLS) : width_q;
		h_eff    = (height_q > 9'(cph_pkg::MAX_ROWS)) ? 9'(cph_pkg::MAX_ROWS) : height_q;
		in_frame = !cx_s4[22] && (cx_s4[21:0] < {13'd0, w_eff}) &&
		           !cy_s4[22] && (cy_s4[21:0] < {13'd0, h_eff});
		entry.col = '0;
		entry.row = '0;
		case (op_s4)
			cph_pkg::OP_CLEAR: begin
				entry.kind = cph_pkg::STAT_CLEARED;
			end
			cph_pkg::OP_READ: begin
				entry.kind = cph_pkg::STAT_READ;
				entry.col  = rc_s4;
				entry.row  = rr_s4;
			end
			default: begin
				if (in_frame) begin
					entry.kind = cph_pkg::STAT_COUNTED;
					entry.col  = cx_s4[cph_pkg::COL_BITS-1:0];
					entry.row  = cy_s4[cph_pkg::ROW_BITS-1:0];
				end else begin
					entry.kind = cph_pkg::STAT_OUTSIDE;
				end
			end
		endcase
		push.valid = v_s4 && !q_full;
		push.entry = entry;
	end

endmodule

// ----- hdl/cph_queue.sv -----
// Short queue of classified items between the front and back ends.
// Flop based, one write and one read per cycle. Uses cph_pkg.
module cph_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  cph_pkg::push_t push,
	output logic           full,
	output cph_pkg::head_t head,
	input  logic           pop
);

	cph_pkg::entry_t                slot_q [cph_pkg::Q_DEPTH];
	logic [cph_pkg::Q_PTR_BITS-1:0] wr_ptr_q;
	logic [cph_pkg::Q_PTR_BITS-1:0] rd_ptr_q;
	logic [cph_pkg::Q_PTR_BITS:0]   count_q;
	logic                           do_pop;

	assign full       = (count_q == (cph_pkg::Q_PTR_BITS+1)'(cph_pkg::Q_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = slot_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	// store pushed entries
	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wr_ptr_q] <= push.entry;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/cph_back.sv -----
// Back end: counter store read-modify-write, peak and totals, clearing
// sweeps and the output register. Uses cph_pkg and cph_ram.
module cph_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cph_pkg::head_t       head,
	output logic                 pop,
	output cph_pkg::back_stat_t  back_stat,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [175:0]         m_axis_tdata,
	output logic [1:0]           m_axis_tuser
);

	localparam logic [1:0] S_INIT  = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;
	localparam logic [1:0] S_CLEAR = 2'd3;

	localparam int CB = cph_pkg::COUNT_BITS;
	localparam int TB = cph_pkg::TOTAL_BITS;

	logic [1:0]                     state_q;
	logic [cph_pkg::ADDR_BITS-1:0]  sweep_q;
	logic [1:0]                     kind_q;
	logic [cph_pkg::COL_BITS-1:0]   col_q;
	logic [cph_pkg::ROW_BITS-1:0]   row_q;
	logic [CB-1:0]                  peak_q;
	logic [TB-1:0]                  inside_q;
	logic [TB-1:0]                  outside_q;
	logic                           out_valid_q;
	logic [1:0]                     out_status_q;
	logic [175:0]                   out_data_q;

	logic                          wr_en;
	logic [cph_pkg::ADDR_BITS-1:0] wr_addr;
	logic [CB-1:0]                 wr_data;
	logic                          rd_en;
	logic [cph_pkg::ADDR_BITS-1:0] rd_addr;
	logic [CB-1:0]                 rd_data;

	logic          out_free;
	logic          fire;
	logic          sweeping;
	logic [CB-1:0] cnt_new;
	logic [CB-1:0] peak_new;
	logic [TB-1:0] inside_new;
	logic [TB-1:0] outside_new;

	// counter store, address is row then column
	cph_ram #(
		.WIDTH(CB),
		.DEPTH(cph_pkg::MAX_COLS * cph_pkg::MAX_ROWS)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign out_free  = !out_valid_q || m_axis_tready;
	assign fire      = (state_q == S_EXEC) && out_free;
	assign sweeping  = (state_q == S_INIT) || (state_q == S_CLEAR);
	assign pop       = (state_q == S_IDLE) && head.valid;
	assign back_stat.init_busy = (state_q == S_INIT);

	// issue the store read as an entry leaves the queue
	assign rd_en   = pop;
	assign rd_addr = {head.entry.row, head.entry.col};

	// updated counter, peak and totals
	always_comb begin
		cnt_new     = (rd_data == '1) ? rd_data : rd_data + 1'b1;
		peak_new    = (cnt_new > peak_q) ? cnt_new : peak_q;
		inside_new  = (inside_q == '1) ? inside_q : inside_q + 1'b1;
		outside_new = (outside_q == '1) ? outside_q : outside_q + 1'b1;
	end

	// store writes: zero during sweeps, new count on a hit
	always_comb begin
		wr_en   = sweeping || (fire && (kind_q == cph_pkg::STAT_COUNTED));
		wr_addr = sweeping ? sweep_q : {row_q, col_q};
		wr_data = sweeping ? '0 : cnt_new;
	end

	// output valid: set on a new result, drop once the transfer is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			sweep_q     <= '0;
			peak_q      <= '0;
			inside_q    <= '0;
			outside_q   <= '0;
		end else begin
			case (state_q)
				S_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (head.valid) begin
						sweep_q <= '0;
						state_q <= (head.entry.kind == cph_pkg::STAT_CLEARED) ? S_CLEAR : S_EXEC;
					end
				end
				S_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == '1) begin
						peak_q    <= '0;
						inside_q  <= '0;
						outside_q <= '0;
						state_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						state_q     <= S_IDLE;
						case (kind_q)
							cph_pkg::STAT_COUNTED: begin
								peak_q   <= peak_new;
								inside_q <= inside_new;
							end
							cph_pkg::STAT_OUTSIDE: begin
								outside_q <= outside_new;
							end
							default: ;
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// latch the entry and build the result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= head.entry.kind;
			col_q  <= head.entry.col;
			row_q  <= head.entry.row;
		end
		if (fire) begin
			out_status_q <= kind_q;
			case (kind_q)
				cph_pkg::STAT_COUNTED: begin
					out_data_q <= {outside_q, inside_new, 32'(peak_new), 32'(cnt_new),
					               row_q, col_q};
				end
				cph_pkg::STAT_OUTSIDE: begin
					out_data_q <= {outside_new, inside_q, 32'(peak_q), 32'd0, 16'd0};
				end
				cph_pkg::STAT_READ: begin
					out_data_q <= {outside_q, inside_q, 32'(peak_q), 32'(rd_data),
					               row_q, col_q};
				end
				default: begin
					out_data_q <= '0;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

endmodule

// ----- hdl/complex_point_histogram.sv -----
// Usage notes:
// Input stream s_axis carries one operation per transfer: add a complex
// point (Q4.28), clear the histogram, or read one counter; the opcode is in
// tuser. Opcode 3 is accepted and dropped with no result.
// Output stream m_axis returns one result per operation: status in tuser,
// pixel, counter, peak and both totals in tdata.
// The cfg channel writes one register per transfer and is always ready;
// write it only while the block is idle.
// From an input transfer to m_axis_tvalid, an operation passes the 4 mapping
// stages, the queue, the store read and the output register.
// The back end takes one add or read at a time: it pops an entry only
// when idle and finishes the store read-modify-write before the next.
// A clear sweeps the 65536-entry store, one entry per cycle, before its
// result is shown. Reset: the whole store is swept to zero; s_axis_tready
// stays low until the sweep completes.
// A stalled receiver holds the output register; the queue and the mapping
// pipeline fill, then s_axis_tready drops.
// Depends on cph_pkg, cph_front, cph_queue, cph_back and cph_ram.
module complex_point_histogram (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// point_real[31:0], point_imag[63:32], read_col[71:64], read_row[79:72]
	input  logic [79:0]  s_axis_tdata,
	// opcode[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// pixel_col[7:0], pixel_row[15:8], pixel_count[47:16], peak_count[79:48],
	// inside_total[127:80], outside_total[175:128]
	output logic [175:0] m_axis_tdata,
	// status[1:0]
	output logic [1:0]   m_axis_tuser
);

	cph_pkg::push_t      push;
	cph_pkg::head_t      head;
	cph_pkg::back_stat_t back_stat;
	logic                q_full;
	logic                pop;

	// accept, map and classify
	cph_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.back_stat    (back_stat),
		.q_full       (q_full),
		.push         (push)
	);

	// decouple the two ends
	cph_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (q_full),
		.head  (head),
		.pop   (pop)
	);

	// update the store and send results
	cph_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.back_stat    (back_stat),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule
